### rtl/core/easing_interpolator_macros.svh
// Assertion helpers for the easing interpolator checker.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef EASING_INTERPOLATOR_MACROS_SVH
`define EASING_INTERPOLATOR_MACROS_SVH

// Same-cycle implication.
`define EINT_ASSERT_IMP(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication.
`define EINT_ASSERT_NXT(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

### rtl/core/eint_pkg.sv
package eint_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int TIME_BITS_DEF = 32;

	localparam int LEVEL_W = 32;
	localparam int DELTA_W = 16;
	localparam int LEN_W   = 32;
	localparam int MODE_W  = 4;
	localparam int PDATA_W = 32;
	localparam int PADDR_W = 4;

	localparam logic FUNC_TICK  = 1'b0;
	localparam logic FUNC_START = 1'b1;

	typedef enum logic [MODE_W-1:0] {
		CURVE_LINEAR = 4'd0,
		QUAD_IN      = 4'd1,
		QUAD_OUT     = 4'd2,
		QUAD_INOUT   = 4'd3,
		QUAD_OUTIN   = 4'd4,
		CUBIC_IN     = 4'd5,
		CUBIC_OUT    = 4'd6,
		CUBIC_INOUT  = 4'd7,
		CUBIC_OUTIN  = 4'd8
	} curve_t;

	typedef enum logic [1:0] {
		REG_START  = 2'd0,
		REG_END    = 2'd1,
		REG_LENGTH = 2'd2,
		REG_CURVE  = 2'd3
	} reg_idx_t;

	// controller -> datapath
	typedef struct packed {
		logic start;
		logic accum;
		logic div_init;
		logic div_step;
		logic mul1;
		logic mul2;
		logic ease;
		logic scale;
		logic emit_prog;
		logic emit_done;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic armed;
		logic reached;
		logic out_busy;
	} sts_t;

endpackage

### rtl/core/eint_channels.sv
interface eint_req_if import eint_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               func;
	logic [DELTA_W-1:0] delta_time;

	modport source(output valid, func, delta_time, input ready);
	modport sink(input valid, func, delta_time, output ready);
endinterface

interface eint_rsp_if import eint_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [LEVEL_W-1:0] level;
	logic                      finished;

	modport source(output valid, level, finished, input ready);
	modport sink(input valid, level, finished, output ready);
endinterface

### rtl/core/easing_interpolator.sv
// Channel   | Dir | Payload                         | Handshake
// ----------+-----+---------------------------------+--------------------------
// req       | in  | func, delta_time                | valid/ready
// rsp       | out | level (Q16.16), finished        | valid/ready
// APB       | in  | start/end level, length, curve  | psel/penable, pready = 1
//
// A start request or a tick while disarmed is accepted in IDLE, no result.
// An armed tick short of the length steps through CHECK, DIVIDE, MUL1, MUL2,
// EASE, SCALE and EMIT; its result is loaded into the output register as EMIT
// leaves. DIVIDE runs the one-bit-per-cycle divider. At completion CHECK goes
// to DONE, which emits the finished result. arst_n clears the sequencer and state.
// A finished result waiting on rsp does not block the next request; the
// sequencer only holds in its last state if a second result is ready first.
module easing_interpolator import eint_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	eint_req_if.sink           req,
	eint_rsp_if.source         rsp
);

	// configuration registers
	logic signed [LEVEL_W-1:0] start_level_q;
	logic signed [LEVEL_W-1:0] end_level_q;
	logic [LEN_W-1:0]          ramp_length_q;
	logic [MODE_W-1:0]         curve_mode_q;

	logic     cfg_we;
	reg_idx_t cfg_idx;

	cmd_t cmd;
	sts_t sts;

	assign pready  = 1'b1;
	assign cfg_we  = psel & penable & pwrite;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	// every write hits a register and stops a running ramp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_level_q <= '0;
			end_level_q   <= '0;
			ramp_length_q <= LEN_W'(1);
			curve_mode_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_START:  start_level_q <= pwdata[LEVEL_W-1:0];
				REG_END:    end_level_q   <= pwdata[LEVEL_W-1:0];
				REG_LENGTH: ramp_length_q <= pwdata[LEN_W-1:0];
				REG_CURVE:  curve_mode_q  <= pwdata[MODE_W-1:0];
				default:    curve_mode_q  <= curve_mode_q;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_START:  prdata = PDATA_W'(start_level_q);
			REG_END:    prdata = PDATA_W'(end_level_q);
			REG_LENGTH: prdata = PDATA_W'(ramp_length_q);
			REG_CURVE:  prdata = PDATA_W'(curve_mode_q);
			default:    prdata = '0;
		endcase
	end

	// sequencer: accept, check, divide, multiply, ease, scale, emit or done
	eint_ctrl #(
		.FRAC_BITS(FRAC_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_func (req.func),
		.req_ready(req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// time accumulator, divider, shared multiplier and result register
	eint_dp #(
		.FRAC_BITS(FRAC_BITS),
		.TIME_BITS(TIME_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_write   (cfg_we),
		.delta_time  (req.delta_time),
		.start_level (start_level_q),
		.end_level   (end_level_q),
		.ramp_length (ramp_length_q),
		.curve_mode  (curve_mode_q),
		.out_ready   (rsp.ready),
		.out_valid   (rsp.valid),
		.out_level   (rsp.level),
		.out_finished(rsp.finished)
	);

endmodule

### rtl/core/eint_ctrl.sv
module eint_ctrl import eint_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_func,
	output logic req_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam int CW = $clog2(FRAC_BITS + 1);

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_CHECK  = 9'b000000010,
		ST_DIVIDE = 9'b000000100,
		ST_MUL1   = 9'b000001000,
		ST_MUL2   = 9'b000010000,
		ST_EASE   = 9'b000100000,
		ST_SCALE  = 9'b001000000,
		ST_EMIT   = 9'b010000000,
		ST_DONE   = 9'b100000000
	} state_t;

	state_t        state_q, state_nxt;
	logic [CW-1:0] cnt_q;
	logic          div_last;

	assign div_last = (cnt_q == CW'(FRAC_BITS - 1));

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					if (req_func == FUNC_START) begin
						cmd.start = 1'b1;
					end else if (sts.armed) begin
						cmd.accum = 1'b1;
						state_nxt = ST_CHECK;
					end
				end
			end
			ST_CHECK: begin
				if (sts.reached) begin
					state_nxt = ST_DONE;
				end else begin
					cmd.div_init = 1'b1;
					state_nxt    = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (div_last) begin
					state_nxt = ST_MUL1;
				end
			end
			ST_MUL1: begin
				cmd.mul1  = 1'b1;
				state_nxt = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2  = 1'b1;
				state_nxt = ST_EASE;
			end
			ST_EASE: begin
				cmd.ease  = 1'b1;
				state_nxt = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (!sts.out_busy) begin
					cmd.emit_prog = 1'b1;
					state_nxt     = ST_IDLE;
				end
			end
			ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.emit_done = 1'b1;
					state_nxt     = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (cmd.div_init) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

endmodule

### rtl/core/eint_dp.sv
module eint_dp import eint_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmd_t                      cmd,
	output sts_t                      sts,
	input  logic                      cfg_write,
	input  logic [DELTA_W-1:0]        delta_time,
	input  logic signed [LEVEL_W-1:0] start_level,
	input  logic signed [LEVEL_W-1:0] end_level,
	input  logic [LEN_W-1:0]          ramp_length,
	input  logic [MODE_W-1:0]         curve_mode,
	input  logic                      out_ready,
	output logic                      out_valid,
	output logic signed [LEVEL_W-1:0] out_level,
	output logic                      out_finished
);

	// fraction operand width: values below 4.0 in curve terms
	localparam int W  = FRAC_BITS + 2;
	localparam int EW = (TIME_BITS > LEN_W) ? TIME_BITS : LEN_W + 1;
	localparam int DW = LEN_W + 1;
	localparam int PW = DW + W;
	localparam int SW = LEVEL_W + 2;

	localparam logic [W-1:0] ONE     = W'(1) << FRAC_BITS;
	localparam logic [W-1:0] TWO_ONE = W'(2) << FRAC_BITS;

	localparam logic signed [SW-1:0] LVL_MAX = SW'({1'b0, {(LEVEL_W-1){1'b1}}});
	localparam logic signed [SW-1:0] LVL_MIN = -LVL_MAX - SW'(1);

	// state
	logic                      armed_q;
	logic [TIME_BITS-1:0]      elapsed_q;
	logic signed [LEVEL_W-1:0] last_level_q;
	logic                      out_valid_q;

	// working registers
	logic [LEN_W-1:0]          rem_q;
	logic [FRAC_BITS-1:0]      t_q;
	logic [W-1:0]              base_q, p1_q, p2_q;
	logic [FRAC_BITS:0]        e_q;
	logic signed [DW-1:0]      diff_q;
	logic signed [PW-1:0]      prod_q;
	logic signed [LEVEL_W-1:0] out_level_q;
	logic                      out_finished_q;

	logic [TIME_BITS:0]   el_sum;
	logic [TIME_BITS-1:0] el_next;
	logic [EW-1:0]        elapsed_x, length_x;
	logic [LEN_W:0]       r2, r_sub;
	logic                 q_bit;

	logic [W-1:0]   t_w, t2, a_hi, x_op, y_op, mul_a, mul_b, e_w;
	logic           low_half;
	logic [2*W-1:0] mul_p;

	logic signed [PW-1:0]      prod_sh;
	logic signed [SW-1:0]      lvl_sum;
	logic signed [LEVEL_W-1:0] lvl_sel;

	// saturating time accumulate
	assign el_sum  = {1'b0, elapsed_q} + (TIME_BITS+1)'(delta_time);
	assign el_next = el_sum[TIME_BITS] ? '1 : el_sum[TIME_BITS-1:0];

	assign elapsed_x = EW'(elapsed_q);
	assign length_x  = EW'(ramp_length);

	// restoring divider, one quotient bit per cycle
	assign r2    = {rem_q, 1'b0};
	assign r_sub = r2 - {1'b0, ramp_length};
	assign q_bit = (r2 >= {1'b0, ramp_length});

	// curve operands
	assign t_w      = W'(t_q);
	assign t2       = t_w << 1;
	assign a_hi     = t2 - ONE;
	assign low_half = ~t_q[FRAC_BITS-1];

	always_comb begin
		x_op = t_w;
		y_op = t_w;
		case (curve_t'(curve_mode))
			QUAD_OUT: begin
				y_op = TWO_ONE - t_w;
			end
			QUAD_INOUT: begin
				if (low_half) begin
					x_op = t2;
					y_op = t2;
				end else begin
					x_op = a_hi;
					y_op = TWO_ONE - a_hi;
				end
			end
			QUAD_OUTIN: begin
				if (low_half) begin
					x_op = t2;
					y_op = TWO_ONE - t2;
				end else begin
					x_op = a_hi;
					y_op = a_hi;
				end
			end
			CUBIC_OUT: begin
				x_op = ONE - t_w;
				y_op = ONE - t_w;
			end
			CUBIC_INOUT: begin
				x_op = low_half ? t2 : TWO_ONE - t2;
				y_op = x_op;
			end
			CUBIC_OUTIN: begin
				x_op = low_half ? ONE - t2 : a_hi;
				y_op = x_op;
			end
			default: begin
				x_op = t_w;
				y_op = t_w;
			end
		endcase
	end

	// one shared multiplier: x_op * y_op first, times x_op again on the second pass (cube)
	assign mul_a = cmd.mul2 ? p1_q : x_op;
	assign mul_b = cmd.mul2 ? base_q : y_op;
	assign mul_p = (2*W)'(mul_a) * (2*W)'(mul_b);

	always_comb begin
		case (curve_t'(curve_mode))
			CURVE_LINEAR: e_w = t_w;
			QUAD_IN:      e_w = p1_q;
			QUAD_OUT:     e_w = p1_q;
			QUAD_INOUT:   e_w = low_half ? (p1_q >> 1) : ((ONE + p1_q) >> 1);
			QUAD_OUTIN:   e_w = low_half ? (p1_q >> 1) : ((ONE + p1_q) >> 1);
			CUBIC_IN:     e_w = p2_q;
			CUBIC_OUT:    e_w = ONE - p2_q;
			CUBIC_INOUT:  e_w = low_half ? (p2_q >> 1) : (ONE - (p2_q >> 1));
			CUBIC_OUTIN:  e_w = low_half ? ((ONE - p2_q) >> 1) : ((ONE + p2_q) >> 1);
			default:      e_w = '0;
		endcase
	end

	// level = start + floor(diff * e / 2^F), saturated; zero for an unknown curve
	assign prod_sh = prod_q >>> FRAC_BITS;
	assign lvl_sum = SW'(start_level) + prod_sh[SW-1:0];

	always_comb begin
		if (curve_mode > MODE_W'(CUBIC_OUTIN)) begin
			lvl_sel = '0;
		end else if (lvl_sum > LVL_MAX) begin
			lvl_sel = LVL_MAX[LEVEL_W-1:0];
		end else if (lvl_sum < LVL_MIN) begin
			lvl_sel = LVL_MIN[LEVEL_W-1:0];
		end else begin
			lvl_sel = lvl_sum[LEVEL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q      <= 1'b0;
			elapsed_q    <= '0;
			last_level_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.start) begin
				armed_q   <= 1'b1;
				elapsed_q <= '0;
			end else if (cmd.accum) begin
				elapsed_q <= el_next;
			end
			if (cfg_write || cmd.emit_done) begin
				armed_q <= 1'b0;
			end
			if (cmd.emit_prog) begin
				last_level_q <= lvl_sel;
			end
			if (cmd.emit_prog || cmd.emit_done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q <= elapsed_x[LEN_W-1:0];
			t_q   <= '0;
		end else if (cmd.div_step) begin
			rem_q <= q_bit ? r_sub[LEN_W-1:0] : r2[LEN_W-1:0];
			t_q   <= {t_q[FRAC_BITS-2:0], q_bit};
		end
		if (cmd.mul1) begin
			p1_q   <= mul_p[FRAC_BITS+W-1:FRAC_BITS];
			base_q <= x_op;
			diff_q <= DW'(end_level) - DW'(start_level);
		end
		if (cmd.mul2) begin
			p2_q <= mul_p[FRAC_BITS+W-1:FRAC_BITS];
		end
		if (cmd.ease) begin
			e_q <= e_w[FRAC_BITS:0];
		end
		if (cmd.scale) begin
			prod_q <= PW'(diff_q) * PW'($signed({1'b0, e_q}));
		end
		if (cmd.emit_prog) begin
			out_level_q    <= lvl_sel;
			out_finished_q <= 1'b0;
		end else if (cmd.emit_done) begin
			out_level_q    <= last_level_q;
			out_finished_q <= 1'b1;
		end
	end

	assign sts.armed    = armed_q;
	assign sts.reached  = (elapsed_x >= length_x);
	assign sts.out_busy = out_valid_q & ~out_ready;

	assign out_valid    = out_valid_q;
	assign out_level    = out_level_q;
	assign out_finished = out_finished_q;

endmodule

### rtl/core/eint_checker.sv
`include "easing_interpolator_macros.svh"

module eint_checker import eint_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               req_func,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic [LEVEL_W-1:0] rsp_level,
	input logic               rsp_finished
);

	logic req_take;
	logic rsp_stall;

	assign req_take  = req_valid & req_ready;
	assign rsp_stall = rsp_valid & ~rsp_ready;

	`EINT_ASSERT_NXT(a_rsp_hold, rsp_stall, rsp_valid, "result dropped while stalled")
	`EINT_ASSERT_NXT(a_rsp_stable, rsp_stall, $stable(rsp_level) && $stable(rsp_finished), "stalled result changed")
	`EINT_ASSERT_NXT(a_start_ready, req_take && (req_func == FUNC_START), req_ready, "start request left block busy")
	`EINT_ASSERT_NXT(a_tick_latency, req_take && (req_func == FUNC_TICK), !$rose(rsp_valid), "result appeared too early")
	`EINT_ASSERT_IMP(a_rose_ready, $rose(rsp_valid), req_ready, "new result while sequencer busy")

endmodule

bind easing_interpolator eint_checker u_eint_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.req_func    (req.func),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_level   (rsp.level),
	.rsp_finished(rsp.finished)
);
